[rtl/crcfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared types, constants and the CRC16/Modbus byte update for the frame
// checker.
// ----------------------------------------------------------------------------
package crcfc_pkg;

   localparam logic [9:0]  FRAME_OVERHEAD = 10'd7;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [8:0]  COUNT_MAX      = 9'd511;

   // Configuration register indexes.
   localparam logic CSR_START_END = 1'b0;
   localparam logic CSR_VERSION   = 1'b1;

   // Role of a byte within its frame.
   typedef enum logic [2:0] {
      POS_START,
      POS_VERSION,
      POS_COMMAND,
      POS_LENGTH,
      POS_PAYLOAD,
      POS_CRC_LO,
      POS_CRC_HI,
      POS_TRAILER
   } pos_type;

   typedef enum logic [2:0] {
      ERR_OK      = 3'd0,
      ERR_SHORT   = 3'd1,
      ERR_START   = 3'd2,
      ERR_END     = 3'd3,
      ERR_VERSION = 3'd4,
      ERR_LENGTH  = 3'd5,
      ERR_CRC     = 3'd6
   } err_type;

   // One classified byte, handed from the front to the back.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
      pos_type    pos;
      logic [7:0] index;
      logic       too_short;
      logic       length_bad;
   } class_type;

   typedef struct packed {
      logic [7:0] start_end_byte;
      logic [7:0] version_byte;
   } cfg_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/crcfc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_front
// Accepts received bytes, tracks the position within the frame and tags each
// item with its role, payload index and the size checks.
// ----------------------------------------------------------------------------
module crcfc_front
   import crcfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_end,
   input  wire logic       queue_full,
   output logic            queue_push,
   output class_type       queue_item
);

   logic [8:0] count_ff, count_in;
   logic [7:0] len_ff, len_in;
   logic       accept;
   logic [9:0] pos_ext;
   logic [9:0] pay_end;
   logic [7:0] len_eff;

   assign accept     = req_push && !queue_full;
   assign req_full   = queue_full;
   assign queue_push = accept;

   assign pos_ext = {1'b0, count_ff};
   assign pay_end = 10'd4 + {2'b00, len_ff};
   assign len_eff = (count_ff == 9'd3) ? req_rx_byte : len_ff;

   always_comb begin
      queue_item.rx_byte    = req_rx_byte;
      queue_item.frame_end  = req_frame_end;
      queue_item.index      = 8'd0;
      queue_item.too_short  = (pos_ext + 10'd1) < FRAME_OVERHEAD;
      queue_item.length_bad = (({2'b00, len_eff} + FRAME_OVERHEAD) != (pos_ext + 10'd1));
      priority if (count_ff == 9'd0) begin
         queue_item.pos = POS_START;
      end else if (count_ff == 9'd1) begin
         queue_item.pos = POS_VERSION;
      end else if (count_ff == 9'd2) begin
         queue_item.pos = POS_COMMAND;
      end else if (count_ff == 9'd3) begin
         queue_item.pos = POS_LENGTH;
      end else if (pos_ext < pay_end) begin
         queue_item.pos   = POS_PAYLOAD;
         queue_item.index = count_ff[7:0] - 8'd4;
      end else if (pos_ext == pay_end) begin
         queue_item.pos = POS_CRC_LO;
      end else if (pos_ext == pay_end + 10'd1) begin
         queue_item.pos = POS_CRC_HI;
      end else begin
         queue_item.pos = POS_TRAILER;
      end
   end

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      if (accept) begin
         if (req_frame_end) begin
            count_in = 9'd0;
            len_in   = 8'd0;
         end else begin
            len_in = len_eff;
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + 9'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 9'd0;
         len_ff   <= 8'd0;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

endmodule
`default_nettype wire

[rtl/crcfc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module crcfc_queue
   import crcfc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  class_type item_in,
   output logic      full,
   input  wire logic pop,
   output class_type item_out,
   output logic      empty
);

   class_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

[rtl/crcfc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcfc_back
// Runs the CRC, delimiter, version and length checks on classified items,
// builds the result and holds finished results in a two-entry output queue.
// ----------------------------------------------------------------------------
module crcfc_back
   import crcfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  cfg_type         cfg,
   input  class_type       item,
   input  wire logic       item_empty,
   output logic            item_pop,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic            rsp_payload_valid,
   output logic [7:0]      rsp_payload_byte,
   output logic [7:0]      rsp_payload_index,
   output logic            rsp_frame_done,
   output logic            rsp_frame_ok,
   output logic [2:0]      rsp_error_code,
   output logic [7:0]      rsp_command_code,
   output logic [7:0]      rsp_payload_length
);

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_done;
      logic       frame_ok;
      err_type    error_code;
      logic [7:0] command_code;
      logic [7:0] payload_length;
   } result_type;

   logic [15:0] crc_ff, crc_in;
   logic        start_ok_ff, start_ok_in;
   logic        version_ok_ff, version_ok_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        crc_match_ff, crc_match_in;

   result_type  result;
   logic        process;
   logic        out_full;

   result_type  out_mem_ff [2];
   logic        out_wr_ff, out_rd_ff;
   logic [1:0]  out_count_ff;
   logic        out_pop;

   assign out_full = (out_count_ff == 2'd2);
   assign process  = !item_empty && !out_full;
   assign item_pop = process;
   assign out_pop  = rsp_pop && !rsp_empty;

   // Frame state update; the verdict below sees the updated values.
   always_comb begin
      crc_in        = crc_ff;
      start_ok_in   = start_ok_ff;
      version_ok_in = version_ok_ff;
      command_in    = command_ff;
      length_in     = length_ff;
      crc_low_in    = crc_low_ff;
      crc_match_in  = crc_match_ff;
      unique case (item.pos)
         POS_START: begin
            start_ok_in = (item.rx_byte == cfg.start_end_byte);
         end
         POS_VERSION: begin
            version_ok_in = (item.rx_byte == cfg.version_byte);
            crc_in        = crc16_update(crc_ff, item.rx_byte);
         end
         POS_COMMAND: begin
            command_in = item.rx_byte;
            crc_in     = crc16_update(crc_ff, item.rx_byte);
         end
         POS_LENGTH: begin
            length_in = item.rx_byte;
            crc_in    = crc16_update(crc_ff, item.rx_byte);
         end
         POS_PAYLOAD: begin
            crc_in = crc16_update(crc_ff, item.rx_byte);
         end
         POS_CRC_LO: begin
            crc_low_in = item.rx_byte;
         end
         POS_CRC_HI: begin
            crc_match_in = ({item.rx_byte, crc_low_ff} == crc_ff);
         end
         POS_TRAILER: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.payload_valid  = (item.pos == POS_PAYLOAD) && !item.frame_end;
      result.payload_byte   = result.payload_valid ? item.rx_byte : 8'd0;
      result.payload_index  = result.payload_valid ? item.index : 8'd0;
      result.frame_done     = item.frame_end;
      result.command_code   = command_in;
      result.payload_length = length_in;
      result.error_code     = ERR_OK;
      if (item.frame_end) begin
         priority if (item.too_short) begin
            result.error_code = ERR_SHORT;
         end else if (!start_ok_in) begin
            result.error_code = ERR_START;
         end else if (item.rx_byte != cfg.start_end_byte) begin
            result.error_code = ERR_END;
         end else if (!version_ok_in) begin
            result.error_code = ERR_VERSION;
         end else if (item.length_bad) begin
            result.error_code = ERR_LENGTH;
         end else if (!crc_match_in) begin
            result.error_code = ERR_CRC;
         end else begin
            result.error_code = ERR_OK;
         end
      end
      result.frame_ok = item.frame_end && (result.error_code == ERR_OK);
   end

   always_ff @(posedge clock) begin
      if (reset || (process && item.frame_end)) begin
         crc_ff        <= CRC_INIT;
         start_ok_ff   <= 1'b0;
         version_ok_ff <= 1'b0;
         command_ff    <= 8'd0;
         length_ff     <= 8'd0;
         crc_low_ff    <= 8'd0;
         crc_match_ff  <= 1'b0;
      end else if (process) begin
         crc_ff        <= crc_in;
         start_ok_ff   <= start_ok_in;
         version_ok_ff <= version_ok_in;
         command_ff    <= command_in;
         length_ff     <= length_in;
         crc_low_ff    <= crc_low_in;
         crc_match_ff  <= crc_match_in;
      end
   end

   // Output queue: a finished result waits here while the next item is worked on.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         if (process) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= !out_rd_ff;
         end
         out_count_ff <= out_count_ff + {1'b0, process} - {1'b0, out_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         out_mem_ff[out_wr_ff] <= result;
      end
   end

   assign rsp_empty          = (out_count_ff == 2'd0);
   assign rsp_payload_valid  = out_mem_ff[out_rd_ff].payload_valid;
   assign rsp_payload_byte   = out_mem_ff[out_rd_ff].payload_byte;
   assign rsp_payload_index  = out_mem_ff[out_rd_ff].payload_index;
   assign rsp_frame_done     = out_mem_ff[out_rd_ff].frame_done;
   assign rsp_frame_ok       = out_mem_ff[out_rd_ff].frame_ok;
   assign rsp_error_code     = out_mem_ff[out_rd_ff].error_code;
   assign rsp_command_code   = out_mem_ff[out_rd_ff].command_code;
   assign rsp_payload_length = out_mem_ff[out_rd_ff].payload_length;

   a_out_count_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= 2'd2)
      else $error("output queue count out of range");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      process && item.frame_end |=> (crc_ff == CRC_INIT) && !start_ok_ff
                                    && !crc_match_ff && (length_ff == 8'd0))
      else $error("frame state not cleared after last byte");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_full && !out_pop |=> out_count_ff == 2'd2)
      else $error("output queue overrun");

endmodule
`default_nettype wire

[rtl/crc16_frame_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_checker
// Streaming frame checker with CRC16/Modbus: payload pass-through with index
// and a verdict on the last byte of each frame.
// ----------------------------------------------------------------------------
// Bytes and results are registered in two-entry queues (item, output) that
// decouple the stages. Throughput: one byte per cycle unless a queue is full;
// the byte-wide CRC update in the back stage is combinational.
// Reset: synchronous, active high; clears the frame state and queues and
// loads the delimiter 0x7E and version 0x01. No clearing pass is needed.
// ----------------------------------------------------------------------------
module crc16_frame_checker
   import crcfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic            rsp_payload_valid,
   output logic [7:0]      rsp_payload_byte,
   output logic [7:0]      rsp_payload_index,
   output logic            rsp_frame_done,
   output logic            rsp_frame_ok,
   output logic [2:0]      rsp_error_code,
   output logic [7:0]      rsp_command_code,
   output logic [7:0]      rsp_payload_length,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_data
);

   cfg_type   cfg_ff;
   logic      queue_full, queue_push, queue_empty, queue_pop;
   class_type front_item, back_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_end_byte <= 8'h7E;
         cfg_ff.version_byte   <= 8'h01;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_END: cfg_ff.start_end_byte <= csr_data;
            CSR_VERSION:   cfg_ff.version_byte   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   crcfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_rx_byte   (req_rx_byte),
      .req_frame_end (req_frame_end),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_item    (front_item)
   );

   crcfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .item_in  (front_item),
      .full     (queue_full),
      .pop      (queue_pop),
      .item_out (back_item),
      .empty    (queue_empty)
   );

   crcfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .item               (back_item),
      .item_empty         (queue_empty),
      .item_pop           (queue_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_error_code     (rsp_error_code),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC16 frame checker testbench
// Streams delimited frames byte by byte into the checker and compares every
// result against a cycle-free model of the frame state. It uses well-formed
// frames with random content, corrupted and truncated frames, noise, and
// register changes between phases, with random sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench
   import crcfc_pkg::*;
();

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } rx_item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_done;
      logic       frame_ok;
      err_type    error_code;
      logic [7:0] command_code;
      logic [7:0] payload_length;
   } frame_result_type;

   typedef enum {
      FR_GOOD,
      FR_BAD_START,
      FR_BAD_END,
      FR_BAD_VERSION,
      FR_BAD_LENGTH,
      FR_BAD_CRC,
      FR_CUT_SHORT,
      FR_NOISE,
      FR_OVERLONG
   } frame_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_end = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_payload_valid;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_index;
   logic       rsp_frame_done;
   logic       rsp_frame_ok;
   logic [2:0] rsp_error_code;
   logic [7:0] rsp_command_code;
   logic [7:0] rsp_payload_length;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_START_END;
   logic [7:0] csr_data = 8'h00;

   rx_item_type      pending_q[$];
   rx_item_type      carry_q[$];
   frame_result_type expected_q[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int queued_items   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // Register copies and frame state of the checker model.
   logic [7:0]  cfg_delim    = 8'h7E;
   logic [7:0]  cfg_version  = 8'h01;
   logic [8:0]  rx_pos       = '0;
   logic [15:0] crc_run      = CRC_INIT;
   logic        start_good   = 1'b0;
   logic        version_good = 1'b0;
   logic [7:0]  cmd_held     = '0;
   logic [7:0]  len_held     = '0;
   logic [7:0]  crc_lo_held  = '0;
   logic        crc_good     = 1'b0;

   crc16_frame_checker dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_rx_byte        (req_rx_byte),
      .req_frame_end      (req_frame_end),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_error_code     (rsp_error_code),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_modbus_next(input logic [15:0] acc,
                                                     input logic [7:0]  data);
      logic [15:0] r;
      r = acc ^ {8'h00, data};
      repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
      return r;
   endfunction

   // Advances the frame state by one byte and returns the result it causes.
   function automatic frame_result_type predict_rx_byte(input logic [7:0] b,
                                                        input logic last);
      frame_result_type r;
      logic [9:0]       pay_end;
      r = '0;
      pay_end = 10'd4 + {2'b00, len_held};
      if (rx_pos == 9'd0) begin
         start_good = (b == cfg_delim);
      end else if (rx_pos == 9'd1) begin
         version_good = (b == cfg_version);
         crc_run = crc16_modbus_next(crc_run, b);
      end else if (rx_pos == 9'd2) begin
         cmd_held = b;
         crc_run = crc16_modbus_next(crc_run, b);
      end else if (rx_pos == 9'd3) begin
         len_held = b;
         crc_run = crc16_modbus_next(crc_run, b);
      end else if ({1'b0, rx_pos} < pay_end) begin
         crc_run = crc16_modbus_next(crc_run, b);
         if (!last) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = 8'(rx_pos - 9'd4);
         end
      end else if ({1'b0, rx_pos} == pay_end) begin
         crc_lo_held = b;
      end else if ({1'b0, rx_pos} == pay_end + 10'd1) begin
         crc_good = ({b, crc_lo_held} == crc_run);
      end

      r.frame_done     = last;
      r.command_code   = cmd_held;
      r.payload_length = len_held;

      if (last) begin
         if ({1'b0, rx_pos} + 10'd1 < FRAME_OVERHEAD) begin
            r.error_code = ERR_SHORT;
         end else if (!start_good) begin
            r.error_code = ERR_START;
         end else if (b != cfg_delim) begin
            r.error_code = ERR_END;
         end else if (!version_good) begin
            r.error_code = ERR_VERSION;
         end else if ({2'b00, len_held} + FRAME_OVERHEAD != {1'b0, rx_pos} + 10'd1) begin
            r.error_code = ERR_LENGTH;
         end else if (!crc_good) begin
            r.error_code = ERR_CRC;
         end else begin
            r.error_code = ERR_OK;
         end
         r.frame_ok   = (r.error_code == ERR_OK);
         rx_pos       = '0;
         crc_run      = CRC_INIT;
         start_good   = 1'b0;
         version_good = 1'b0;
         cmd_held     = '0;
         len_held     = '0;
         crc_lo_held  = '0;
         crc_good     = 1'b0;
      end else if (rx_pos != COUNT_MAX) begin
         rx_pos = rx_pos + 9'd1;
      end
      return r;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   task automatic compare_result();
      frame_result_type want;
      if (expected_q.size() == 0) begin
         mismatch_count++;
         $display("%0t: result with no item outstanding, expected none, actual done=%0b err=%0d",
                  $time, rsp_frame_done, rsp_error_code);
      end else begin
         want = expected_q.pop_front();
         check_field("payload_valid", want.payload_valid, rsp_payload_valid);
         check_field("payload_byte", want.payload_byte, rsp_payload_byte);
         check_field("payload_index", want.payload_index, rsp_payload_index);
         check_field("frame_done", want.frame_done, rsp_frame_done);
         check_field("frame_ok", want.frame_ok, rsp_frame_ok);
         check_field("error_code", want.error_code, rsp_error_code);
         check_field("command_code", want.command_code, rsp_command_code);
         check_field("payload_length", want.payload_length, rsp_payload_length);
      end
   endtask

   // Monitor: checks the departing result before modeling the arriving byte.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            compare_result();
         end
         if (req_push && !req_full) begin
            expected_q.push_back(predict_rx_byte(req_rx_byte, req_frame_end));
            void'(pending_q.pop_front());
         end
      end
   end

   // Driver: offers the oldest pending item unless the sender idles this cycle.
   always @(negedge clock) begin
      if (reset || pending_q.size() == 0 || $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
      end else begin
         req_push      <= 1'b1;
         req_rx_byte   <= pending_q[0].rx_byte;
         req_frame_end <= pending_q[0].frame_end;
      end
      rsp_pop <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] other_than(input logic [7:0] x);
      return x ^ 8'($urandom_range(1, 255));
   endfunction

   task automatic push_item(input logic [7:0] b, input logic last);
      pending_q.push_back('{b, last});
      queued_items++;
   endtask

   // Builds one frame with the current register values. Bytes from position
   // split on are held back so that the frame straddles a register change.
   task automatic queue_frame(input frame_kind_type kind, input int len, input int split);
      logic [7:0]  fb[$];
      logic [15:0] crc;
      int          body;
      int          keep;
      int          i;
      body = len;
      if (kind == FR_BAD_LENGTH) begin
         do body = $urandom_range(len + 3); while (body == len);
      end else if (kind == FR_OVERLONG) begin
         body = $urandom_range(510, 520);
      end

      if (kind == FR_NOISE) begin
         repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
      end else begin
         fb.push_back(kind == FR_BAD_START ? other_than(cfg_delim) : cfg_delim);
         fb.push_back(kind == FR_BAD_VERSION ? other_than(cfg_version) : cfg_version);
         fb.push_back(8'($urandom));
         fb.push_back(8'(len));
         repeat (body) fb.push_back(8'($urandom));
         crc = CRC_INIT;
         for (i = 1; i < fb.size(); i++) crc = crc16_modbus_next(crc, fb[i]);
         if (kind == FR_BAD_CRC) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
         end
         fb.push_back(crc[7:0]);
         fb.push_back(crc[15:8]);
         fb.push_back(kind == FR_BAD_END ? other_than(cfg_delim) : cfg_delim);
         if (kind == FR_CUT_SHORT) begin
            keep = $urandom_range(1, fb.size() - 1);
            while (fb.size() > keep) void'(fb.pop_back());
            // A proper delimiter on the cut byte lets later checks decide.
            if ($urandom_range(1) == 1) begin
               fb[keep - 1] = cfg_delim;
            end
         end
      end

      for (i = 0; i < fb.size(); i++) begin
         if (split > 0 && i >= split) begin
            carry_q.push_back('{fb[i], i == fb.size() - 1});
            queued_items++;
         end else begin
            push_item(fb[i], i == fb.size() - 1);
         end
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_START_END) begin
         cfg_delim = value;
      end else begin
         cfg_version = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || expected_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      int             phase;
      int             random_start;
      int             phase_end;
      int             pick;
      int             len;
      frame_kind_type kind;
      logic [15:0]    dir_crc;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one-byte and two-byte frames, a good frame with a full-scale
      // payload byte, a CRC error, and a frame that ends inside its payload.
      push_item(8'h00, 1'b1);
      push_item(8'hFF, 1'b0);
      push_item(8'h7E, 1'b1);
      push_item(8'h7E, 1'b0);
      push_item(8'h01, 1'b0);
      push_item(8'hA5, 1'b0);
      push_item(8'h01, 1'b0);
      push_item(8'hFF, 1'b0);
      dir_crc = crc16_modbus_next(crc16_modbus_next(crc16_modbus_next(
                crc16_modbus_next(CRC_INIT, 8'h01), 8'hA5), 8'h01), 8'hFF);
      push_item(dir_crc[7:0], 1'b0);
      push_item(dir_crc[15:8], 1'b0);
      push_item(8'h7E, 1'b1);
      queue_frame(FR_BAD_CRC, 0, 0);
      push_item(8'h7E, 1'b0);
      push_item(8'h01, 1'b0);
      push_item(8'h5A, 1'b0);
      push_item(8'h03, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h7E, 1'b1);
      wait_drained();

      random_start = queued_items;
      phase = 0;
      while (queued_items - random_start < RANDOM_ITEMS) begin
         wait_drained();
         if (phase > 0) begin
            case (phase % 5)
               1: begin
                  write_reg(CSR_START_END, 8'h00);
                  write_reg(CSR_VERSION, 8'hFF);
               end
               2: begin
                  write_reg(CSR_START_END, 8'hFF);
                  write_reg(CSR_VERSION, 8'h00);
               end
               3: begin
                  write_reg(CSR_VERSION, 8'h01);
                  write_reg(CSR_START_END, 8'h7E);
               end
               default: begin
                  write_reg(CSR_START_END, 8'($urandom));
                  write_reg(CSR_VERSION, 8'($urandom));
               end
            endcase
         end
         while (carry_q.size() != 0) pending_q.push_back(carry_q.pop_front());

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 67;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 67;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct = 18;
            end
         endcase

         // The byte counter only saturates on a frame longer than 512 bytes.
         if (phase == 0) begin
            queue_frame(FR_OVERLONG, $urandom_range(255), 0);
         end

         phase_end = queued_items + $urandom_range(150, 250);
         while (queued_items < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 60)      kind = FR_GOOD;
            else if (pick < 65) kind = FR_BAD_START;
            else if (pick < 70) kind = FR_BAD_END;
            else if (pick < 75) kind = FR_BAD_VERSION;
            else if (pick < 81) kind = FR_BAD_LENGTH;
            else if (pick < 87) kind = FR_BAD_CRC;
            else if (pick < 94) kind = FR_CUT_SHORT;
            else                kind = FR_NOISE;
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(0, 6);
            else if (pick < 98) len = $urandom_range(7, 40);
            else                len = $urandom_range(41, 255);
            queue_frame(kind, len, 0);
         end

         // Leave a frame open so the next register write lands mid-frame.
         if ($urandom_range(1) == 1) begin
            queue_frame(FR_GOOD, $urandom_range(0, 6), $urandom_range(1, 3));
         end
         phase++;
      end

      wait_drained();
      while (carry_q.size() != 0) pending_q.push_back(carry_q.pop_front());
      wait_drained();
      repeat (10) @(negedge clock);

      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
